### hw/rtl/tmvrd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the ternary matrix-vector row dot block.
// No dependencies; used by ternary_matvec_row_dot_top.
package tmvrd_pkg;

   // Longest supported row; longer row_length settings clamp to this
   localparam logic [16:0] MAX_ROW_LENGTH = 17'd65536;

   // Configuration register indexes
   localparam logic [1:0] CSR_ROW_LENGTH   = 2'd0;
   localparam logic [1:0] CSR_GROUP_SIZE   = 2'd1;
   localparam logic [1:0] CSR_USE_GROUPS   = 2'd2;
   localparam logic [1:0] CSR_GLOBAL_SCALE = 2'd3;

   // Ternary weight codes; the other two codes mean zero
   localparam logic [1:0] WCODE_PLUS  = 2'd1;
   localparam logic [1:0] WCODE_MINUS = 2'd2;

   // Reset values of the configuration registers
   localparam logic [16:0]        ROW_LENGTH_RESET   = 17'd1;
   localparam logic [16:0]        GROUP_SIZE_RESET   = 17'd1;
   localparam logic signed [31:0] GLOBAL_SCALE_RESET = 32'sd65536;

   // Input word
   typedef struct packed {
      logic [1:0]         weight_code;
      logic signed [31:0] activation;
      logic signed [31:0] group_scale;
   } req_item_type;

   // Result word
   typedef struct packed {
      logic signed [63:0] row_result;
      logic [15:0]        row_number;
   } rsp_item_type;

   // What an element adds to the row sum at the accumulator
   typedef enum logic [1:0] {
      ADD_NONE   = 2'd0,
      ADD_RAW    = 2'd1,
      ADD_SCALED = 2'd2
   } addend_kind_type;

   // Side info that travels alongside the group-scale multiplier
   typedef struct packed {
      logic               valid;
      addend_kind_type    kind;
      logic signed [32:0] term;
      logic               row_end;
      logic               grouped;
      logic [15:0]        row_number;
   } tail_item_type;

   // Side info that travels alongside the global-scale multiplier
   typedef struct packed {
      logic               valid;
      logic               grouped;
      logic signed [63:0] row_sum;
      logic [15:0]        row_number;
   } head_item_type;

   // 64-bit add that clamps to the signed range
   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic [64:0] sum;
      sum = {a[63], a} + {b[63], b};
      if (sum[64] != sum[63]) begin
         sat_add64 = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sat_add64 = sum[63:0];
      end
   endfunction

endpackage

### hw/rtl/tmvrd_scale.sv
`timescale 1ns / 1ps
// Four-stage Q16.16 scaling multiplier: (a * s) >> 16, rounded half away from
// zero, saturated to 64 bits. Uses no package items.
module tmvrd_scale (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [63:0] a_in,
   input  logic signed [31:0] s_in,
   output logic signed [63:0] p_out
);

   logic        neg1_ff, neg2_ff, neg3_ff;
   logic [63:0] ua1_ff;
   logic [31:0] us1_ff;
   logic [63:0] p0_ff, p1_ff;
   logic [95:0] full_ff;
   logic [63:0] p_ff;

   logic [63:0] ua_in;
   logic [31:0] us_in;
   logic [63:0] p0_in, p1_in;
   logic [95:0] full_in;
   logic [63:0] mag;
   logic        over;
   logic [63:0] p_in;

   // stage 1: sign and magnitudes
   assign ua_in = a_in[63] ? (~a_in + 64'd1) : a_in;
   assign us_in = s_in[31] ? (~s_in + 32'd1) : s_in;

   // stage 2: two 32x32 partial products
   assign p0_in = {32'd0, ua1_ff[31:0]} * {32'd0, us1_ff};
   assign p1_in = {32'd0, ua1_ff[63:32]} * {32'd0, us1_ff};

   // stage 3: combine partials and add the rounding half
   assign full_in = {32'd0, p0_ff} + {p1_ff, 32'd0} + 96'h8000;

   // stage 4: drop fraction, clamp, restore sign
   assign over = (full_ff[95:80] != 16'd0) || full_ff[79];
   assign mag  = full_ff[79:16];
   always_comb begin
      if (neg3_ff) begin
         p_in = over ? {1'b1, 63'd0} : (~mag + 64'd1);
      end else begin
         p_in = over ? {1'b0, {63{1'b1}}} : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         neg1_ff <= a_in[63] ^ s_in[31];
         ua1_ff  <= ua_in;
         us1_ff  <= us_in;
         neg2_ff <= neg1_ff;
         p0_ff   <= p0_in;
         p1_ff   <= p1_in;
         neg3_ff <= neg2_ff;
         full_ff <= full_in;
         p_ff    <= p_in;
      end
   end

   assign p_out = p_ff;

endmodule

### hw/rtl/ternary_matvec_row_dot_top.sv
`timescale 1ns / 1ps
// Top level of the ternary matrix-vector row dot block.
// Depends on tmvrd_pkg and tmvrd_scale.

// Takes one weight/activation word per cycle while req_ready is high and returns one
// result word per finished row, row index attached. Throughput is one word per
// clock while no result waits; the group sum and the row sum are each a
// combinational saturating add into its own register, which is what sets that
// rate. After the accepting edge, at which the input register takes the word, the
// group-sum stage, four-stage group-scale multiplier, row-sum accumulator,
// four-stage global-scale multiplier and result register follow; the last drives rsp_valid.
// The whole pipe advances whenever the result register is empty or being
// taken, so req_ready drops only while a result waits. Configuration writes
// must happen with the pipe drained.
module ternary_matvec_row_dot_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tmvrd_pkg::req_item_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tmvrd_pkg::rsp_item_type rsp_data,
   input  logic                    csr_wr_en,
   input  logic [1:0]              csr_index,
   input  logic [31:0]             csr_wr_data
);

   // configuration registers
   logic [16:0]        row_length_ff;
   logic [16:0]        group_size_ff;
   logic               use_groups_ff;
   logic signed [31:0] global_scale_ff;

   // input stage
   logic                    in_valid_ff;
   tmvrd_pkg::req_item_type in_item_ff;

   // front accumulation state
   logic signed [47:0] group_sum_ff, group_sum_in;
   logic [15:0]        element_position_ff, element_position_in;
   logic [15:0]        group_position_ff, group_position_in;
   logic [15:0]        row_counter_ff, row_counter_in;

   // handoff to the group-scale multiplier
   tmvrd_pkg::tail_item_type s1_item_ff, s1_item_in;
   logic signed [63:0]       s1_a_ff;
   logic signed [31:0]       s1_scale_ff;
   tmvrd_pkg::tail_item_type sa_ff [4];

   // row accumulator and handoff to the global-scale multiplier
   logic signed [63:0]       row_sum_ff, row_sum_in;
   tmvrd_pkg::head_item_type p6_item_ff, p6_item_in;
   tmvrd_pkg::head_item_type sb_ff [4];

   // result register
   logic                    rsp_valid_ff;
   tmvrd_pkg::rsp_item_type rsp_data_ff;

   logic               adv;
   logic [16:0]        len_eff, gsz_eff;
   logic [16:0]        elem_next, grp_next;
   logic               row_end, group_end;
   logic signed [32:0] term;
   logic [48:0]        gsum_wide;
   logic signed [47:0] gsum_sat;
   logic signed [63:0] group_scaled, row_scaled;
   logic signed [63:0] addend, row_sum_new;

   // pipe moves when the result register is free
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff   <= tmvrd_pkg::ROW_LENGTH_RESET;
         group_size_ff   <= tmvrd_pkg::GROUP_SIZE_RESET;
         use_groups_ff   <= 1'b0;
         global_scale_ff <= tmvrd_pkg::GLOBAL_SCALE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            tmvrd_pkg::CSR_ROW_LENGTH:   row_length_ff   <= csr_wr_data[16:0];
            tmvrd_pkg::CSR_GROUP_SIZE:   group_size_ff   <= csr_wr_data[16:0];
            tmvrd_pkg::CSR_USE_GROUPS:   use_groups_ff   <= csr_wr_data[0];
            tmvrd_pkg::CSR_GLOBAL_SCALE: global_scale_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_valid;
         in_item_ff  <= req_data;
      end
   end

   // effective row length and group size
   always_comb begin
      if (row_length_ff == 17'd0) begin
         len_eff = 17'd1;
      end else if (row_length_ff > tmvrd_pkg::MAX_ROW_LENGTH) begin
         len_eff = tmvrd_pkg::MAX_ROW_LENGTH;
      end else begin
         len_eff = row_length_ff;
      end
      gsz_eff = (group_size_ff == 17'd0) ? 17'd1 : group_size_ff;
   end

   assign elem_next = {1'b0, element_position_ff} + 17'd1;
   assign grp_next  = {1'b0, group_position_ff} + 17'd1;
   assign row_end   = elem_next >= len_eff;
   assign group_end = row_end || (grp_next >= gsz_eff);

   // signed term from the weight code
   always_comb begin
      case (in_item_ff.weight_code)
         tmvrd_pkg::WCODE_PLUS:  term = {in_item_ff.activation[31], in_item_ff.activation};
         tmvrd_pkg::WCODE_MINUS: term = ~{in_item_ff.activation[31], in_item_ff.activation}
                                        + 33'd1;
         default:                term = 33'sd0;
      endcase
   end

   // saturating group sum
   assign gsum_wide = {group_sum_ff[47], group_sum_ff} + {{16{term[32]}}, term};
   always_comb begin
      if (gsum_wide[48] != gsum_wide[47]) begin
         gsum_sat = gsum_wide[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
         gsum_sat = gsum_wide[47:0];
      end
   end

   // front state update and handoff word
   always_comb begin
      group_sum_in        = group_sum_ff;
      element_position_in = element_position_ff;
      group_position_in   = group_position_ff;
      row_counter_in      = row_counter_ff;

      s1_item_in.valid      = in_valid_ff;
      s1_item_in.term       = term;
      s1_item_in.row_end    = row_end;
      s1_item_in.grouped    = use_groups_ff;
      s1_item_in.row_number = row_counter_ff;
      if (use_groups_ff) begin
         s1_item_in.kind = group_end ? tmvrd_pkg::ADD_SCALED : tmvrd_pkg::ADD_NONE;
      end else begin
         s1_item_in.kind = tmvrd_pkg::ADD_RAW;
      end

      if (in_valid_ff) begin
         if (use_groups_ff) begin
            group_sum_in = group_end ? 48'sd0 : gsum_sat;
         end
         group_position_in = group_end ? 16'd0 : grp_next[15:0];
         if (row_end) begin
            group_sum_in        = 48'sd0;
            element_position_in = 16'd0;
            group_position_in   = 16'd0;
            row_counter_in      = row_counter_ff + 16'd1;
         end else begin
            element_position_in = elem_next[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_sum_ff        <= 48'sd0;
         element_position_ff <= 16'd0;
         group_position_ff   <= 16'd0;
         row_counter_ff      <= 16'd0;
         s1_item_ff.valid    <= 1'b0;
      end else if (adv) begin
         group_sum_ff        <= group_sum_in;
         element_position_ff <= element_position_in;
         group_position_ff   <= group_position_in;
         row_counter_ff      <= row_counter_in;
         s1_item_ff          <= s1_item_in;
         s1_a_ff             <= {{16{gsum_sat[47]}}, gsum_sat};
         s1_scale_ff         <= in_item_ff.group_scale;
      end
   end

   // group-scale multiplier
   tmvrd_scale u_group_scale (
      .clock  (clock),
      .enable (adv),
      .a_in   (s1_a_ff),
      .s_in   (s1_scale_ff),
      .p_out  (group_scaled)
   );

   // side info delay matching the multiplier
   always_ff @(posedge clock) begin
      if (reset) begin
         sa_ff[0].valid <= 1'b0;
         sa_ff[1].valid <= 1'b0;
         sa_ff[2].valid <= 1'b0;
         sa_ff[3].valid <= 1'b0;
      end else if (adv) begin
         sa_ff[0] <= s1_item_ff;
         sa_ff[1] <= sa_ff[0];
         sa_ff[2] <= sa_ff[1];
         sa_ff[3] <= sa_ff[2];
      end
   end

   // row accumulator, in element order
   always_comb begin
      case (sa_ff[3].kind)
         tmvrd_pkg::ADD_RAW:    addend = {{31{sa_ff[3].term[32]}}, sa_ff[3].term};
         tmvrd_pkg::ADD_SCALED: addend = group_scaled;
         default:               addend = 64'sd0;
      endcase
   end

   assign row_sum_new = tmvrd_pkg::sat_add64(row_sum_ff, addend);

   always_comb begin
      row_sum_in = row_sum_ff;
      if (sa_ff[3].valid) begin
         row_sum_in = sa_ff[3].row_end ? 64'sd0 : row_sum_new;
      end
      p6_item_in.valid      = sa_ff[3].valid && sa_ff[3].row_end;
      p6_item_in.grouped    = sa_ff[3].grouped;
      p6_item_in.row_sum    = row_sum_new;
      p6_item_in.row_number = sa_ff[3].row_number;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_sum_ff       <= 64'sd0;
         p6_item_ff.valid <= 1'b0;
      end else if (adv) begin
         row_sum_ff <= row_sum_in;
         p6_item_ff <= p6_item_in;
      end
   end

   // global-scale multiplier
   tmvrd_scale u_global_scale (
      .clock  (clock),
      .enable (adv),
      .a_in   (p6_item_ff.row_sum),
      .s_in   (global_scale_ff),
      .p_out  (row_scaled)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_ff[0].valid <= 1'b0;
         sb_ff[1].valid <= 1'b0;
         sb_ff[2].valid <= 1'b0;
         sb_ff[3].valid <= 1'b0;
      end else if (adv) begin
         sb_ff[0] <= p6_item_ff;
         sb_ff[1] <= sb_ff[0];
         sb_ff[2] <= sb_ff[1];
         sb_ff[3] <= sb_ff[2];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff           <= sb_ff[3].valid;
         rsp_data_ff.row_result <= sb_ff[3].grouped ? sb_ff[3].row_sum : row_scaled;
         rsp_data_ff.row_number <= sb_ff[3].row_number;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // group position never runs ahead of the element position
   a_group_within_row: assert property (@(posedge clock) disable iff (reset)
      group_position_ff <= element_position_ff)
      else $error("group position beyond element position");

   // row accumulator clears after a row end passes
   a_row_sum_clear: assert property (@(posedge clock) disable iff (reset)
      adv && sa_ff[3].valid && sa_ff[3].row_end |=> row_sum_ff == 64'sd0)
      else $error("row sum not cleared at row end");

   // a result appears only from the last multiplier stage
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(sb_ff[3].valid))
      else $error("result without a finished row");
`endif

endmodule
